// ===== rtl/core/color_blend_mode_mixer_macros.svh =====
// Assertion macros for the color blend mixer.
// No dependencies; included by files that carry concurrent assertions.
`ifndef COLOR_BLEND_MODE_MIXER_MACROS_SVH
`define COLOR_BLEND_MODE_MIXER_MACROS_SVH

// Same-cycle implication, disabled while in reset.
`define CBM_ASSERT_IMPL(name, clk_s, rst_s, ante, cons) \
	name: assert property (@(posedge clk_s) disable iff (!rst_s) (ante) |-> (cons)) \
		else $error("cbm property violated");

// Next-cycle implication, disabled while in reset.
`define CBM_ASSERT_NEXT(name, clk_s, rst_s, ante, cons) \
	name: assert property (@(posedge clk_s) disable iff (!rst_s) (ante) |=> (cons)) \
		else $error("cbm property violated");

`endif

// ===== rtl/core/cbm_pkg.sv =====
// Shared types and constants of the color blend mixer.
// No dependencies; imported by the queue, the front, the back and the top level.
package cbm_pkg;

	localparam int unsigned CHANNELS = 3;

	// Field slots of one queue entry.
	localparam int unsigned ENT_FACTOR   = 0;
	localparam int unsigned ENT_BASE_R   = 1;
	localparam int unsigned ENT_ALPHA    = 4;
	localparam int unsigned ENT_BLEND_R  = 5;
	localparam int unsigned ENT_VMAX     = 8;
	localparam int unsigned ENT_BMAX     = 9;
	localparam int unsigned ENTRY_FIELDS = 10;

	localparam int unsigned QUEUE_DEPTH = 4;
	localparam int unsigned QUEUE_AW    = 2;

	typedef struct packed {
		logic full;
		logic empty;
	} q_stat_t;

endpackage

// ===== rtl/core/cbm_if.sv =====
// Valid/ready channel interfaces of the color blend mixer: pixel in, result out.
// No dependencies.
interface cbm_pixel_if #(
	parameter int unsigned W = 16
) ();
	logic         valid;
	logic         ready;
	logic [W-1:0] factor;
	logic [W-1:0] base_red;
	logic [W-1:0] base_green;
	logic [W-1:0] base_blue;
	logic [W-1:0] base_alpha;
	logic [W-1:0] blend_red;
	logic [W-1:0] blend_green;
	logic [W-1:0] blend_blue;
	logic [W-1:0] blend_alpha;

	modport source (
		output valid, factor, base_red, base_green, base_blue, base_alpha,
		output blend_red, blend_green, blend_blue, blend_alpha,
		input  ready
	);
	modport sink (
		input  valid, factor, base_red, base_green, base_blue, base_alpha,
		input  blend_red, blend_green, blend_blue, blend_alpha,
		output ready
	);
endinterface

interface cbm_result_if #(
	parameter int unsigned W = 16
) ();
	logic         valid;
	logic         ready;
	logic [W-1:0] mixed_red;
	logic [W-1:0] mixed_green;
	logic [W-1:0] mixed_blue;
	logic [W-1:0] mixed_alpha;

	modport source (
		output valid, mixed_red, mixed_green, mixed_blue, mixed_alpha,
		input  ready
	);
	modport sink (
		input  valid, mixed_red, mixed_green, mixed_blue, mixed_alpha,
		output ready
	);
endinterface

// ===== rtl/core/color_blend_mode_mixer.sv =====
// Top level of the color blend mixer: front, transaction queue and back.
// Depends on cbm_pkg, cbm_if, cbm_front, cbm_queue, cbm_back and the macro header.
//
//   channel  | modport        | carries
//   pixel    | cbm_pixel_if   | factor, base RGBA, blend RGBA
//   result   | cbm_result_if  | mixed RGBA
//   cfg      | we / wdata     | alpha_multiply
//
// One transaction per cycle sustained while the result is not stalled; the divider
// pipeline in the back computes one quotient bit per stage.
// Reset clears valids, queue pointers and alpha_multiply; no clearing pass.
// A stalled result freezes the back; the four-entry queue absorbs the front,
// and pixel.ready drops only when the queue is full.
`include "color_blend_mode_mixer_macros.svh"

module color_blend_mode_mixer import cbm_pkg::*; #(
	parameter int unsigned CHANNEL_BITS = 16
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          cfg_we,
	input  logic          cfg_wdata,
	cbm_pixel_if.sink     pixel,
	cbm_result_if.source  result
);
	logic                                      alpha_multiply_q;
	q_stat_t                                   q_stat;
	logic                                      q_push;
	logic                                      q_pop;
	logic [ENTRY_FIELDS-1:0][CHANNEL_BITS-1:0] push_entry;
	logic [ENTRY_FIELDS-1:0][CHANNEL_BITS-1:0] pop_entry;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			alpha_multiply_q <= 1'b0;
		end else if (cfg_we) begin
			alpha_multiply_q <= cfg_wdata;
		end
	end

	cbm_front #(.W(CHANNEL_BITS)) u_front (
		.clk            (clk),
		.arst_n         (arst_n),
		.alpha_multiply (alpha_multiply_q),
		.pixel          (pixel),
		.q_stat         (q_stat),
		.q_push         (q_push),
		.q_entry        (push_entry)
	);

	cbm_queue #(.W(CHANNEL_BITS)) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (q_push),
		.push_entry (push_entry),
		.pop        (q_pop),
		.pop_entry  (pop_entry),
		.stat       (q_stat)
	);

	cbm_back #(.W(CHANNEL_BITS)) u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.q_stat  (q_stat),
		.q_entry (pop_entry),
		.q_pop   (q_pop),
		.result  (result)
	);

	`CBM_ASSERT_IMPL(a_no_push_full, clk, arst_n, q_push, !q_stat.full)
	`CBM_ASSERT_IMPL(a_no_pop_empty, clk, arst_n, q_pop, !q_stat.empty)
	`CBM_ASSERT_IMPL(a_flags_excl, clk, arst_n, 1'b1, !(q_stat.full && q_stat.empty))
	`CBM_ASSERT_NEXT(a_cfg_write, clk, arst_n, cfg_we, alpha_multiply_q == $past(cfg_wdata))
endmodule

// ===== rtl/core/cbm_div_maxv.sv =====
// Divide by the full-scale code 2^W-1 (floor) with a reciprocal estimate
// and one correction step. No dependencies.
module cbm_div_maxv #(
	parameter int unsigned W = 16
) (
	input  logic [2*W-1:0] x,
	output logic [W-1:0]   q
);
	localparam logic [W-1:0] MAXV = '1;

	logic [2*W:0] acc;
	logic [W:0]   q0;
	logic [2*W:0] rem;

	// q0 is floor(x/MAXV) or one below it
	assign acc = {1'b0, x} + (2*W+1)'(x[2*W-1:W]);
	assign q0  = acc[2*W:W];
	assign rem = {1'b0, x} - {q0, {W{1'b0}}} + (2*W+1)'(q0);
	assign q   = (rem >= (2*W+1)'(MAXV)) ? q0[W-1:0] + W'(1) : q0[W-1:0];
endmodule

// ===== rtl/core/cbm_queue.sv =====
// Four-entry transaction queue between the front and the back.
// Depends on cbm_pkg.
module cbm_queue import cbm_pkg::*; #(
	parameter int unsigned W = 16
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           push,
	input  logic [ENTRY_FIELDS-1:0][W-1:0] push_entry,
	input  logic                           pop,
	output logic [ENTRY_FIELDS-1:0][W-1:0] pop_entry,
	output q_stat_t                        stat
);
	logic [ENTRY_FIELDS-1:0][W-1:0] slot_q [QUEUE_DEPTH];
	logic [QUEUE_AW:0]              wr_q;
	logic [QUEUE_AW:0]              rd_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q <= '0;
			rd_q <= '0;
		end else begin
			if (push) begin
				wr_q <= wr_q + (QUEUE_AW+1)'(1);
			end
			if (pop) begin
				rd_q <= rd_q + (QUEUE_AW+1)'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_q[QUEUE_AW-1:0]] <= push_entry;
		end
	end

	assign pop_entry  = slot_q[rd_q[QUEUE_AW-1:0]];
	assign stat.empty = (wr_q == rd_q);
	assign stat.full  = (wr_q[QUEUE_AW] != rd_q[QUEUE_AW]) &&
		(wr_q[QUEUE_AW-1:0] == rd_q[QUEUE_AW-1:0]);
endmodule

// ===== rtl/core/cbm_front.sv =====
// Front: accepts pixels, applies alpha multiply, finds channel extremes and
// classifies gray blend colors. Depends on cbm_pkg, cbm_if, cbm_div_maxv.
module cbm_front import cbm_pkg::*; #(
	parameter int unsigned W = 16
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           alpha_multiply,
	cbm_pixel_if.sink                      pixel,
	input  q_stat_t                        q_stat,
	output logic                           q_push,
	output logic [ENTRY_FIELDS-1:0][W-1:0] q_entry
);
	localparam logic [W-1:0]   MAXV = '1;
	localparam logic [2*W-1:0] HALF = (2*W)'(MAXV >> 1);

	logic adv;
	logic v_s1;
	logic v_s2;

	logic [W-1:0]   vmax_c;
	logic [W-1:0]   bmax_c;
	logic [W-1:0]   bmin_c;
	logic [2*W-1:0] am_prod_c;

	logic [2*W-1:0]           am_prod_s1;
	logic [W-1:0]             factor_s1;
	logic [W-1:0]             alpha_s1;
	logic [W-1:0]             vmax_s1;
	logic [W-1:0]             bmax_s1;
	logic                     pass_s1;
	logic [CHANNELS-1:0][W-1:0] base_s1;
	logic [CHANNELS-1:0][W-1:0] blend_s1;

	logic [2*W-1:0] am_x;
	logic [W-1:0]   am_f;
	logic [W-1:0]   f_c;

	logic [ENTRY_FIELDS-1:0][W-1:0] entry_s2;

	always_comb begin
		vmax_c = (pixel.base_red > pixel.base_green) ? pixel.base_red : pixel.base_green;
		if (pixel.base_blue > vmax_c) begin
			vmax_c = pixel.base_blue;
		end
		bmax_c = (pixel.blend_red > pixel.blend_green) ? pixel.blend_red : pixel.blend_green;
		if (pixel.blend_blue > bmax_c) begin
			bmax_c = pixel.blend_blue;
		end
		bmin_c = (pixel.blend_red < pixel.blend_green) ? pixel.blend_red : pixel.blend_green;
		if (pixel.blend_blue < bmin_c) begin
			bmin_c = pixel.blend_blue;
		end
	end

	assign am_prod_c = pixel.factor * pixel.blend_alpha;

	assign adv         = ~v_s2 | ~q_stat.full;
	assign pixel.ready = adv;
	assign q_push      = v_s2 & ~q_stat.full;
	assign q_entry     = entry_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else if (adv) begin
			v_s1 <= pixel.valid;
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			am_prod_s1  <= am_prod_c;
			factor_s1   <= pixel.factor;
			alpha_s1    <= pixel.base_alpha;
			vmax_s1     <= vmax_c;
			bmax_s1     <= bmax_c;
			pass_s1     <= (bmax_c == bmin_c);
			base_s1[0]  <= pixel.base_red;
			base_s1[1]  <= pixel.base_green;
			base_s1[2]  <= pixel.base_blue;
			blend_s1[0] <= pixel.blend_red;
			blend_s1[1] <= pixel.blend_green;
			blend_s1[2] <= pixel.blend_blue;
		end
	end

	assign am_x = am_prod_s1 + HALF;

	cbm_div_maxv #(.W(W)) u_am_div (
		.x (am_x),
		.q (am_f)
	);

	// zero factor on a gray blend color returns the base color exactly
	always_comb begin
		if (pass_s1) begin
			f_c = '0;
		end else if (alpha_multiply) begin
			f_c = am_f;
		end else begin
			f_c = factor_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			entry_s2[ENT_FACTOR] <= f_c;
			entry_s2[ENT_ALPHA]  <= alpha_s1;
			entry_s2[ENT_VMAX]   <= vmax_s1;
			entry_s2[ENT_BMAX]   <= bmax_s1;
			for (int c = 0; c < CHANNELS; c++) begin
				entry_s2[ENT_BASE_R + c]  <= base_s1[c];
				entry_s2[ENT_BLEND_R + c] <= blend_s1[c];
			end
		end
	end
endmodule

// ===== rtl/core/cbm_back.sv =====
// Back: target color by a pipelined restoring divider, then the weighted
// blend and rounding. Depends on cbm_pkg, cbm_if, cbm_div_maxv.
module cbm_back import cbm_pkg::*; #(
	parameter int unsigned W = 16
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  q_stat_t                        q_stat,
	input  logic [ENTRY_FIELDS-1:0][W-1:0] q_entry,
	output logic                           q_pop,
	cbm_result_if.source                   result
);
	localparam logic [W-1:0]   MAXV = '1;
	localparam logic [2*W-1:0] HALF = (2*W)'(MAXV >> 1);

	logic adv;

	logic                         v_s1;
	logic [CHANNELS-1:0][2*W-1:0] prod_s1;
	logic [CHANNELS-1:0][W-1:0]   base_s1;
	logic [W-1:0]                 f_s1;
	logic [W-1:0]                 alpha_s1;
	logic [W-1:0]                 bmax_s1;

	logic [W-1:0]               v_s2;
	logic [CHANNELS-1:0][W-1:0] rem_s2  [W];
	logic [CHANNELS-1:0][W-1:0] quo_s2  [W];
	logic [CHANNELS-1:0][W-1:0] low_s2  [W];
	logic [CHANNELS-1:0][W-1:0] base_s2 [W];
	logic [W-1:0]               f_s2    [W];
	logic [W-1:0]               alpha_s2[W];
	logic [W-1:0]               bmax_s2 [W];

	logic                         v_s3;
	logic [CHANNELS-1:0][2*W-1:0] pa_s3;
	logic [CHANNELS-1:0][2*W-1:0] pb_s3;
	logic [W-1:0]                 alpha_s3;

	logic                         v_s4;
	logic [CHANNELS-1:0][2*W-1:0] sum_s4;
	logic [W-1:0]                 alpha_s4;

	logic                       v_s5;
	logic [CHANNELS-1:0][W-1:0] mix_s5;
	logic [W-1:0]               alpha_s5;
	logic [CHANNELS-1:0][W-1:0] mix_c;

	assign adv   = ~v_s5 | result.ready;
	assign q_pop = adv & ~q_stat.empty;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else if (adv) begin
			v_s1 <= ~q_stat.empty;
			v_s3 <= v_s2[W-1];
			v_s4 <= v_s3;
			v_s5 <= v_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			f_s1     <= q_entry[ENT_FACTOR];
			alpha_s1 <= q_entry[ENT_ALPHA];
			bmax_s1  <= q_entry[ENT_BMAX];
			for (int c = 0; c < CHANNELS; c++) begin
				prod_s1[c] <= q_entry[ENT_BLEND_R + c] * q_entry[ENT_VMAX];
				base_s1[c] <= q_entry[ENT_BASE_R + c];
			end
		end
	end

	// one quotient bit per stage, MSB first
	for (genvar k = 0; k < W; k++) begin : g_div
		logic                         v_in;
		logic [CHANNELS-1:0][W-1:0]   rem_in;
		logic [CHANNELS-1:0][W-1:0]   quo_in;
		logic [CHANNELS-1:0][W-1:0]   low_in;
		logic [CHANNELS-1:0][W-1:0]   base_in;
		logic [W-1:0]                 f_in;
		logic [W-1:0]                 alpha_in;
		logic [W-1:0]                 bmax_in;
		logic [CHANNELS-1:0][W:0]     trial;
		logic [CHANNELS-1:0]          take;

		if (k == 0) begin : g_first
			logic [CHANNELS-1:0][2*W-1:0] num;
			always_comb begin
				for (int c = 0; c < CHANNELS; c++) begin
					num[c]    = prod_s1[c] + (2*W)'(bmax_s1 >> 1);
					rem_in[c] = num[c][2*W-1:W];
					low_in[c] = num[c][W-1:0];
				end
			end
			assign v_in     = v_s1;
			assign quo_in   = '0;
			assign base_in  = base_s1;
			assign f_in     = f_s1;
			assign alpha_in = alpha_s1;
			assign bmax_in  = bmax_s1;
		end else begin : g_next
			assign v_in     = v_s2[k-1];
			assign rem_in   = rem_s2[k-1];
			assign low_in   = low_s2[k-1];
			assign quo_in   = quo_s2[k-1];
			assign base_in  = base_s2[k-1];
			assign f_in     = f_s2[k-1];
			assign alpha_in = alpha_s2[k-1];
			assign bmax_in  = bmax_s2[k-1];
		end

		always_comb begin
			for (int c = 0; c < CHANNELS; c++) begin
				trial[c] = {rem_in[c], low_in[c][W-1]};
				take[c]  = (trial[c] >= {1'b0, bmax_in});
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s2[k] <= 1'b0;
			end else if (adv) begin
				v_s2[k] <= v_in;
			end
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				for (int c = 0; c < CHANNELS; c++) begin
					rem_s2[k][c] <= take[c] ? W'(trial[c] - {1'b0, bmax_in}) : trial[c][W-1:0];
					quo_s2[k][c] <= {quo_in[c][W-2:0], take[c]};
					low_s2[k][c] <= {low_in[c][W-2:0], 1'b0};
				end
				base_s2[k]  <= base_in;
				f_s2[k]     <= f_in;
				alpha_s2[k] <= alpha_in;
				bmax_s2[k]  <= bmax_in;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			alpha_s3 <= alpha_s2[W-1];
			alpha_s4 <= alpha_s3;
			alpha_s5 <= alpha_s4;
			mix_s5   <= mix_c;
			for (int c = 0; c < CHANNELS; c++) begin
				pa_s3[c]  <= (MAXV - f_s2[W-1]) * base_s2[W-1][c];
				pb_s3[c]  <= f_s2[W-1] * quo_s2[W-1][c];
				sum_s4[c] <= pa_s3[c] + pb_s3[c] + HALF;
			end
		end
	end

	for (genvar c = 0; c < CHANNELS; c++) begin : g_round
		cbm_div_maxv #(.W(W)) u_mix_div (
			.x (sum_s4[c]),
			.q (mix_c[c])
		);
	end

	assign result.valid       = v_s5;
	assign result.mixed_red   = mix_s5[0];
	assign result.mixed_green = mix_s5[1];
	assign result.mixed_blue  = mix_s5[2];
	assign result.mixed_alpha = alpha_s5;
endmodule
